>>> hdl/udiv_pkg.sv
`timescale 1ns / 1ps

package udiv_pkg;

	localparam int DIVIDEND_WIDTH = 64;
	localparam int DIVISOR_WIDTH  = 32;
	localparam int CNT_W          = $clog2(DIVIDEND_WIDTH);
	localparam int IN_DATA_W      = ((DIVIDEND_WIDTH + DIVISOR_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W     = ((DIVIDEND_WIDTH + DIVISOR_WIDTH + 7) / 8) * 8;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} cmd_t;

endpackage

>>> hdl/udiv_ctrl.sv
`timescale 1ns / 1ps

module udiv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output udiv_pkg::cmd_t  cmd
);

	udiv_pkg::state_t             state_q;
	udiv_pkg::state_t             state_d;
	logic [udiv_pkg::CNT_W-1:0]   cnt_q;
	logic                         out_valid_q;
	logic                         last;
	logic                         out_free;

	assign last     = (cnt_q == '0);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			udiv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = udiv_pkg::ST_RUN;
				end
			end
			udiv_pkg::ST_RUN: begin
				if (last && out_free) begin
					state_d = udiv_pkg::ST_IDLE;
				end
			end
			default: state_d = udiv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			udiv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			udiv_pkg::ST_RUN: begin
				// hold the final step until the result register is free
				cmd.step    = !last || out_free;
				cmd.publish = last && out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= udiv_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= udiv_pkg::CNT_W'(udiv_pkg::DIVIDEND_WIDTH - 1);
			end else if (cmd.step && !last) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/udiv_dp.sv
`timescale 1ns / 1ps

module udiv_dp (
	input  logic                                 clk,
	input  udiv_pkg::cmd_t                       cmd,
	input  logic [udiv_pkg::DIVIDEND_WIDTH-1:0]  dividend,
	input  logic [udiv_pkg::DIVISOR_WIDTH-1:0]   divisor,
	output logic [udiv_pkg::DIVIDEND_WIDTH-1:0]  quotient,
	output logic [udiv_pkg::DIVISOR_WIDTH-1:0]   remainder,
	output logic                                 divide_error
);

	localparam int DW = udiv_pkg::DIVIDEND_WIDTH;
	localparam int RW = udiv_pkg::DIVISOR_WIDTH;

	// quo_q starts as the dividend; quotient bits shift in at the bottom
	logic [DW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsr_q;
	logic          err_q;

	logic [DW-1:0] quo_out_q;
	logic [RW-1:0] rem_out_q;
	logic          err_out_q;

	logic [RW:0]   trial;
	logic [RW+1:0] diff;
	logic          ge;
	logic [RW-1:0] rem_next;
	logic [DW-1:0] quo_next;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign diff     = {1'b0, trial} - {2'b00, dsr_q};
	assign ge       = !diff[RW+1];
	assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
	assign quo_next = {quo_q[DW-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
			err_q <= (divisor == '0);
		end else if (cmd.step) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
		end
		if (cmd.publish) begin
			quo_out_q <= err_q ? '0 : quo_next;
			rem_out_q <= err_q ? '0 : rem_next;
			err_out_q <= err_q;
		end
	end

	assign quotient     = quo_out_q;
	assign remainder    = rem_out_q;
	assign divide_error = err_out_q;

endmodule

>>> hdl/unsigned_divider_64_by_32.sv
`timescale 1ns / 1ps

// Channel   Bus        Contents (tdata low bit up)               tuser
// input     s_axis_*   dividend[63:0], divisor[95:64]            -
// output    m_axis_*   quotient[63:0], remainder[95:64]          divide_error
//
// One quotient bit per cycle while the result register is free, through a single
// 34-bit subtractor: a transfer in is followed by the step cycles, the last of
// which loads the result register, and only then is a new item taken.
// Reset clears the controller only; the datapath registers carry no reset.
// A stalled result holds the final step; the input is taken again only once
// the result register has been loaded, even while that result still waits.

module unsigned_divider_64_by_32 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// dividend[63:0], divisor[95:64]
	input  logic [udiv_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// quotient[63:0], remainder[95:64]
	output logic [udiv_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// divide_error[0]
	output logic                               m_axis_tuser
);

	localparam int DW = udiv_pkg::DIVIDEND_WIDTH;
	localparam int RW = udiv_pkg::DIVISOR_WIDTH;

	udiv_pkg::cmd_t cmd;
	logic [DW-1:0]  quotient;
	logic [RW-1:0]  remainder;

	udiv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	udiv_dp u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.dividend     (s_axis_tdata[DW-1:0]),
		.divisor      (s_axis_tdata[DW+RW-1:DW]),
		.quotient     (quotient),
		.remainder    (remainder),
		.divide_error (m_axis_tuser)
	);

	assign m_axis_tdata = udiv_pkg::OUT_DATA_W'({remainder, quotient});

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten while stalled");

	// one item in flight: after a transfer in, the input closes
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while busy");

	// divide error returns zero quotient and remainder
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("nonzero data with divide error");

	// a result appears only the cycle after the last step loads it
	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.publish))
		else $error("result valid without publish");

endmodule
